>>> sv/vre_pkg.sv
// Shared types and constants for the Verlet residual error block.
// Used by the divider and the top level; no dependencies.
package vre_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int NUM_DIMS_DEF      = 2;

  localparam int POS_W     = 32;
  localparam int PART_W    = 6;
  localparam int SLOT_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = 72;
  localparam int ERR_W     = 64;

  localparam logic [SLOT_W-1:0] SLOT_PREV = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_CUR  = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_NEXT = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_AMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DT2 = 2'd1;

  localparam logic [31:0] AMP_RESET = 32'h0001_0000;
  localparam logic [31:0] DT2_RESET = 32'h0001_0000;

  // r^4 floor of 1e-16 in unsigned Q64.64.
  localparam logic [127:0] R4_FLOOR  = 128'd1845;
  localparam logic [63:0]  FORCE_MAX = 64'h3FFF_FFFF_FFFF_FFFF;

  // Pair force numerator is |A|*|d| shifted up by 51, always below 2^114.
  localparam int NUM_SHIFT = 51;
  localparam int DIV_NUM_W = 114;
  localparam int DIV_DEN_W = 128;

endpackage

>>> sv/verlet_residual_error.sv
// The evaluation time is set mainly by the bit-serial force divider, which runs once for
// each component of each ordered particle pair.
// Loading takes one cycle per item; items are held off while an evaluation runs.
// Throughput: one evaluation at a time, from a position memory with one read port.
// Reset (asynchronous, active low) clears control, the count and the sum, presets amp and
// dt2; datapath registers and the position memory keep no reset value.
module verlet_residual_error #(
  parameter int MaxParticles = vre_pkg::MAX_PARTICLES_DEF,
  parameter int NumDims      = vre_pkg::NUM_DIMS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // particle [5:0], pos_x [37:6], pos_y [69:38], zero fill [71:70]
  input  logic [vre_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // time_offset [1:0]
  input  logic [vre_pkg::SLOT_W-1:0]      s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // residual_error [63:0]
  output logic [vre_pkg::ERR_W-1:0]       m_axis_tdata,
  // error_saturated [0]
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vre_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import vre_pkg::*;

  localparam int CntW  = $clog2(MaxParticles + 1);
  localparam int Depth = 3 * MaxParticles;
  localparam int AddrW = $clog2(Depth);
  localparam int RowW  = NumDims * POS_W;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SELF_RD = 5'd1;
  localparam logic [4:0] S_SELF_LD = 5'd2;
  localparam logic [4:0] S_OTHER   = 5'd3;
  localparam logic [4:0] S_DIFF    = 5'd4;
  localparam logic [4:0] S_SQ      = 5'd5;
  localparam logic [4:0] S_R4      = 5'd6;
  localparam logic [4:0] S_NUM     = 5'd7;
  localparam logic [4:0] S_DIV     = 5'd8;
  localparam logic [4:0] S_PREV_RD = 5'd9;
  localparam logic [4:0] S_PREV_LD = 5'd10;
  localparam logic [4:0] S_NEXT_LD = 5'd11;
  localparam logic [4:0] S_T0      = 5'd12;
  localparam logic [4:0] S_T1      = 5'd13;
  localparam logic [4:0] S_RESID   = 5'd14;
  localparam logic [4:0] S_ACC     = 5'd15;
  localparam logic [4:0] S_DONE    = 5'd16;

  function automatic logic [AddrW-1:0] row_addr(logic [SLOT_W-1:0] slot,
                                                logic [CntW-1:0] idx);
    return AddrW'(32'(slot) * 32'(MaxParticles) + 32'(idx));
  endfunction

  logic [4:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, p_q, p_d, o_q, o_d;
  logic            k_q, k_d;
  logic [1:0]      st_q, st_d;
  logic [31:0]     amp_q, amp_d, dt2_q, dt2_d;
  logic [63:0]     acc_q, acc_d;
  logic            sat_q, sat_d;
  logic            out_valid_q, out_valid_d;
  logic [63:0]     out_data_q, out_data_d;
  logic            out_sat_q, out_sat_d;

  logic [NumDims-1:0][31:0] self_q, self_d, prev_q, prev_d, next_q, next_d;
  logic [NumDims-1:0][31:0] dm_q, dm_d;
  logic [NumDims-1:0]       dneg_q, dneg_d;
  logic [NumDims-1:0][63:0] force_q, force_d;
  logic [63:0]  s_q, s_d;
  logic [127:0] r4_q, r4_d;
  logic [31:0]  t0_q, t0_d;
  logic [63:0]  term_q, term_d, rm_q, rm_d;

  logic             in_acc, part_ok;
  logic [SLOT_W-1:0] in_slot;
  logic [PART_W-1:0] in_part;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [RowW-1:0]  wr_data, rd_data;
  logic [NumDims-1:0][31:0] rd_row;

  logic                 div_start, div_busy, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den;

  logic [32:0]  diff33;
  logic [63:0]  sq, pp, prod, cmag, comp, fsum, fm, res, rsq;
  logic [64:0]  s_add, acc_add;
  logic [127:0] pp_sh;
  logic [31:0]  amp_mag, pa, pb;
  logic         qsat, cneg, last_dim, big;

  assign in_slot = s_axis_tuser;
  assign in_part = s_axis_tdata[PART_W-1:0];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign part_ok = 32'(in_part) < 32'(MaxParticles);
  assign cfg_ready_o = 1'b1;

  assign wr_en   = in_acc && (in_slot != SLOT_NONE) && part_ok;
  assign wr_addr = row_addr(in_slot, CntW'(in_part));
  always_comb begin
    for (int k = 0; k < NumDims; k++) begin
      wr_data[k*POS_W +: POS_W] = (k == 0) ? s_axis_tdata[37:6] : s_axis_tdata[69:38];
    end
  end
  assign rd_row = rd_data;

  vre_store #(.Depth(Depth), .Width(RowW), .AddrW(AddrW)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  vre_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign amp_mag  = amp_q[31] ? (32'd0 - amp_q) : amp_q;
  assign last_dim = (32'(k_q) == NumDims - 1);
  assign div_den  = (r4_q < R4_FLOOR) ? R4_FLOOR : r4_q;

  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;  p_d = p_q;  o_d = o_q;  k_d = k_q;  st_d = st_q;
    amp_d = amp_q;  dt2_d = dt2_q;  acc_d = acc_q;  sat_d = sat_q;
    out_valid_d = out_valid_q;  out_data_d = out_data_q;  out_sat_d = out_sat_q;
    self_d = self_q;  prev_d = prev_q;  next_d = next_q;  dm_d = dm_q;  dneg_d = dneg_q;
    force_d = force_q;  s_d = s_q;  r4_d = r4_q;  t0_d = t0_q;  term_d = term_q;  rm_d = rm_q;
    rd_en = 1'b0;  rd_addr = '0;  div_start = 1'b0;  div_num = '0;
    diff33 = '0;  sq = '0;  s_add = '0;  pa = '0;  pb = '0;  pp = '0;  pp_sh = '0;
    prod = '0;  qsat = 1'b0;  cmag = '0;  cneg = 1'b0;  comp = '0;  fsum = '0;  fm = '0;
    res = '0;  rsq = '0;  big = 1'b0;  acc_add = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_AMP: amp_d = cfg_data_i;
        REG_DT2: dt2_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_slot != SLOT_NONE && s_axis_tlast) begin
          cnt_d = part_ok ? CntW'(32'(in_part) + 32'd1) : CntW'(MaxParticles);
          p_d = '0;
          acc_d = '0;
          sat_d = 1'b0;
          state_d = S_SELF_RD;
        end
      end
      S_SELF_RD: begin
        rd_en = 1'b1;
        rd_addr = row_addr(SLOT_CUR, p_q);
        o_d = '0;
        force_d = '0;
        state_d = S_SELF_LD;
      end
      S_SELF_LD: begin
        self_d = rd_row;
        state_d = S_OTHER;
      end
      S_OTHER: begin
        if (o_q == cnt_q) begin
          state_d = S_PREV_RD;
        end else if (o_q == p_q) begin
          o_d = o_q + 1'b1;
        end else begin
          rd_en = 1'b1;
          rd_addr = row_addr(SLOT_CUR, o_q);
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        for (int k = 0; k < NumDims; k++) begin
          diff33 = {rd_row[k][31], rd_row[k]} - {self_q[k][31], self_q[k]};
          dneg_d[k] = diff33[32];
          dm_d[k] = diff33[32] ? 32'(33'd0 - diff33) : diff33[31:0];
        end
        s_d = '0;
        k_d = 1'b0;
        state_d = S_SQ;
      end
      S_SQ: begin
        sq = dm_q[k_q] * dm_q[k_q];
        s_add = {1'b0, s_q} + {1'b0, sq};
        s_d = s_add[64] ? '1 : s_add[63:0];
        if (last_dim) begin
          r4_d = '0;
          st_d = 2'd0;
          state_d = S_R4;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_R4: begin
        // r^4 = s*s built from four 32x32 partial products.
        pa = st_q[0] ? s_q[63:32] : s_q[31:0];
        pb = st_q[1] ? s_q[63:32] : s_q[31:0];
        pp = pa * pb;
        case (st_q)
          2'd0:    pp_sh = {64'd0, pp};
          2'd3:    pp_sh = {pp, 64'd0};
          default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        r4_d = r4_q + pp_sh;
        st_d = st_q + 1'b1;
        if (st_q == 2'd3) begin
          k_d = 1'b0;
          state_d = S_NUM;
        end
      end
      S_NUM: begin
        prod = amp_mag * dm_q[k_q];
        div_num = {prod[DIV_NUM_W-NUM_SHIFT-1:0], {NUM_SHIFT{1'b0}}};
        div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          qsat = |div_quot[DIV_NUM_W-1:62];
          cmag = qsat ? FORCE_MAX : {2'b00, div_quot[61:0]};
          cneg = amp_q[31] ^ dneg_q[k_q];
          comp = cneg ? (64'd0 - cmag) : cmag;
          fsum = force_q[k_q] + comp;
          if (qsat) sat_d = 1'b1;
          if ($signed(fsum) > $signed(FORCE_MAX)) begin
            force_d[k_q] = FORCE_MAX;
            sat_d = 1'b1;
          end else if ($signed(fsum) < -$signed(FORCE_MAX)) begin
            force_d[k_q] = 64'd0 - FORCE_MAX;
            sat_d = 1'b1;
          end else begin
            force_d[k_q] = fsum;
          end
          if (last_dim) begin
            o_d = o_q + 1'b1;
            state_d = S_OTHER;
          end else begin
            k_d = k_q + 1'b1;
            state_d = S_NUM;
          end
        end
      end
      S_PREV_RD: begin
        rd_en = 1'b1;
        rd_addr = row_addr(SLOT_PREV, p_q);
        state_d = S_PREV_LD;
      end
      S_PREV_LD: begin
        prev_d = rd_row;
        rd_en = 1'b1;
        rd_addr = row_addr(SLOT_NEXT, p_q);
        state_d = S_NEXT_LD;
      end
      S_NEXT_LD: begin
        next_d = rd_row;
        k_d = 1'b0;
        state_d = S_T0;
      end
      S_T0: begin
        fm = force_q[k_q][63] ? (64'd0 - force_q[k_q]) : force_q[k_q];
        prod = dt2_q * fm[31:0];
        t0_d = prod[63:32];
        state_d = S_T1;
      end
      S_T1: begin
        fm = force_q[k_q][63] ? (64'd0 - force_q[k_q]) : force_q[k_q];
        prod = dt2_q * fm[63:32];
        term_d = prod + {32'd0, t0_q};
        state_d = S_RESID;
      end
      S_RESID: begin
        res = {{32{next_q[k_q][31]}}, next_q[k_q]}
            - {{31{self_q[k_q][31]}}, self_q[k_q], 1'b0}
            + {{32{prev_q[k_q][31]}}, prev_q[k_q]};
        res = force_q[k_q][63] ? (res + term_q) : (res - term_q);
        rm_d = res[63] ? (64'd0 - res) : res;
        state_d = S_ACC;
      end
      S_ACC: begin
        big = |rm_q[63:32];
        rsq = big ? '1 : (rm_q[31:0] * rm_q[31:0]);
        acc_add = {1'b0, acc_q} + {1'b0, rsq};
        if (big || acc_add[64]) sat_d = 1'b1;
        acc_d = acc_add[64] ? '1 : acc_add[63:0];
        if (last_dim) begin
          p_d = p_q + 1'b1;
          state_d = (p_q + 1'b1 == cnt_q) ? S_DONE : S_SELF_RD;
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_T0;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d = acc_q;
          out_sat_d = sat_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      p_q <= '0;
      o_q <= '0;
      k_q <= 1'b0;
      st_q <= '0;
      amp_q <= AMP_RESET;
      dt2_q <= DT2_RESET;
      acc_q <= '0;
      sat_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      p_q <= p_d;
      o_q <= o_d;
      k_q <= k_d;
      st_q <= st_d;
      amp_q <= amp_d;
      dt2_q <= dt2_d;
      acc_q <= acc_d;
      sat_q <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_sat_q <= out_sat_d;
    self_q <= self_d;
    prev_q <= prev_d;
    next_q <= next_d;
    dm_q <= dm_d;
    dneg_q <= dneg_d;
    force_q <= force_d;
    s_q <= s_d;
    r4_q <= r4_d;
    t0_q <= t0_d;
    term_q <= term_d;
    rm_q <= rm_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

`ifndef NO_ASSERTIONS
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");
  a_loop_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OTHER) |-> (o_q <= cnt_q) && (p_q < cnt_q))
    else $error("particle loop index out of range");
  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_IDLE) && !rd_en)
    else $error("store written during an evaluation");
`endif

endmodule

>>> sv/vre_div.sv
// Restoring divider, one quotient bit per cycle, for the pair force magnitude.
// Depends on vre_pkg for the operand widths.
module vre_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [vre_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [vre_pkg::DIV_DEN_W-1:0]   den_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [vre_pkg::DIV_NUM_W-1:0]   quot_o
);
  import vre_pkg::*;

  localparam int CntW = $clog2(DIV_NUM_W);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] work_q, work_d;
  logic [DIV_NUM_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;

  logic [DIV_NUM_W:0]   shifted;
  logic [DIV_DEN_W-1:0] shifted_ext;
  logic [DIV_DEN_W-1:0] diff;
  logic                 ge;

  // The quotient bits shift into the numerator register as its bits leave.
  always_comb begin
    shifted     = {rem_q, work_q[DIV_NUM_W-1]};
    shifted_ext = {{(DIV_DEN_W-DIV_NUM_W-1){1'b0}}, shifted};
    ge          = shifted_ext >= den_q;
    diff        = shifted_ext - den_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      work_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      work_d = {work_q[DIV_NUM_W-2:0], ge};
      rem_d  = ge ? diff[DIV_NUM_W-1:0] : shifted[DIV_NUM_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(DIV_NUM_W-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = work_q;

`ifndef NO_ASSERTIONS
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished run");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q != CntW'(DIV_NUM_W-1)) |=> busy_q)
    else $error("divider stopped early");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> busy_q && cnt_q == '0)
    else $error("divider failed to start");
`endif

endmodule

>>> sv/vre_store.sv
// Position store: one row per slice and particle holding all coordinates.
// Synchronous memory, one write and one registered read port; no package use.
module vre_store #(
  parameter int Depth = 192,
  parameter int Width = 64,
  parameter int AddrW = 8
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the Verlet residual error block.
// Depends on vre_pkg and verlet_residual_error; predicts each result in fixed point.
module tb_top;
  import vre_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [PART_W-1:0] part;
    logic [31:0]       pos_x;
    logic [31:0]       pos_y;
    logic              last;
  } pos_item_t;

  typedef struct packed {
    logic [63:0] err;
    logic        sat;
  } err_result_t;

  typedef enum int {LAYOUT_NEAR, LAYOUT_WIDE, LAYOUT_EXTREME, LAYOUT_COINCIDE} layout_e;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [SLOT_W-1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [ERR_W-1:0] m_axis_tdata;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  verlet_residual_error dut (.*);

  pos_item_t   pending_items[$];
  err_result_t expected_errors[$];
  pos_item_t   cur_item;
  bit          item_taken;
  bit          no_idle;
  int          errors;
  int          idle_cycles;

  // Predictor state.
  logic [31:0] pos_mem [3][64][2];
  logic [6:0]  part_count;
  logic [31:0] amp_reg, dt2_reg;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint clamp_force(longint v, inout bit sat);
    longint fmax;
    fmax = longint'(FORCE_MAX);
    if (v > fmax) begin
      sat = 1'b1;
      return fmax;
    end
    if (v < -fmax) begin
      sat = 1'b1;
      return -fmax;
    end
    return v;
  endfunction

  function automatic err_result_t residual_sum();
    err_result_t r;
    bit sat;
    longint force_v[2], d[2], amp, res, term;
    logic [63:0] mag, s, amp_mag;
    logic [64:0] sum65;
    logic [127:0] r4, num, q, t, sq;
    sat = 1'b0;
    amp = longint'(signed'(amp_reg));
    amp_mag = amp < 0 ? 64'(-amp) : 64'(amp);
    sum65 = '0;
    for (int p = 0; p < part_count; p++) begin
      force_v[0] = 0;
      force_v[1] = 0;
      for (int o = 0; o < part_count; o++) begin
        if (o == p) continue;
        s = '0;
        for (int k = 0; k < 2; k++) begin
          logic [64:0] acc;
          d[k] = longint'(signed'(pos_mem[1][o][k])) - longint'(signed'(pos_mem[1][p][k]));
          mag = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
          acc = {1'b0, s} + {1'b0, mag * mag};
          s = acc[64] ? '1 : acc[63:0];
        end
        r4 = {64'd0, s} * {64'd0, s};
        if (r4 < R4_FLOOR) r4 = R4_FLOOR;
        for (int k = 0; k < 2; k++) begin
          longint comp;
          mag = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
          num = ({64'd0, amp_mag} * {64'd0, mag}) << NUM_SHIFT;
          q = num / r4;
          if (q > {64'd0, FORCE_MAX}) begin
            sat = 1'b1;
            comp = longint'(FORCE_MAX);
          end else begin
            comp = longint'(q[63:0]);
          end
          if ((amp < 0) != (d[k] < 0)) comp = -comp;
          force_v[k] = clamp_force(force_v[k] + comp, sat);
        end
      end
      for (int k = 0; k < 2; k++) begin
        mag = force_v[k] < 0 ? 64'(-force_v[k]) : 64'(force_v[k]);
        t = {96'd0, dt2_reg} * {64'd0, mag};
        term = longint'(t[95:32]);
        if (force_v[k] < 0) term = -term;
        res = longint'(signed'(pos_mem[2][p][k])) - 2 * longint'(signed'(pos_mem[1][p][k]))
            + longint'(signed'(pos_mem[0][p][k])) - term;
        mag = res < 0 ? 64'(-res) : 64'(res);
        sq = {64'd0, mag} * {64'd0, mag};
        if (sq[127:64] != 0) begin
          sat = 1'b1;
          sq = {64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
        end
        sum65 = {1'b0, sum65[63:0]} + {1'b0, sq[63:0]};
        if (sum65[64]) begin
          sat = 1'b1;
          sum65 = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
        end
      end
    end
    r.err = sum65[63:0];
    r.sat = sat;
    return r;
  endfunction

  task automatic absorb_item(pos_item_t it);
    if (it.slot == SLOT_NONE) return;
    pos_mem[it.slot][it.part][0] = it.pos_x;
    pos_mem[it.slot][it.part][1] = it.pos_y;
    if (it.last) begin
      part_count = 7'(it.part) + 7'd1;
      expected_errors.push_back(residual_sum());
    end
  endtask

  // Input driver.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      absorb_item(cur_item);
      item_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || item_taken) begin
      item_taken = 1'b0;
      if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 32)) begin
        cur_item = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, cur_item.pos_y, cur_item.pos_x, cur_item.part};
        s_axis_tuser  <= cur_item.slot;
        s_axis_tlast  <= cur_item.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(negedge clk_i) begin
    m_axis_tready <= no_idle || $urandom_range(99) >= 32;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_errors.size() == 0) begin
        $display("%0t: unexpected result err=%h sat=%b", $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        err_result_t e;
        e = expected_errors.pop_front();
        if (m_axis_tdata !== e.err) begin
          $display("%0t: residual_error expected %h actual %h", $time, e.err, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== e.sat) begin
          $display("%0t: error_saturated expected %b actual %b", $time, e.sat, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    if (idx == REG_AMP) amp_reg = value;
    else if (idx == REG_DT2) dt2_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_errors.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord(layout_e lay, logic [31:0] base);
    case (lay)
      LAYOUT_NEAR: begin
        return base + 32'($urandom_range(8191)) - 32'd4096;
      end
      LAYOUT_EXTREME: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'd0;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // One full load of three slices for n particles, ending in the marked item.
  task automatic push_frame(int n, layout_e lay);
    pos_item_t frame[$];
    pos_item_t it;
    logic [31:0] cx, cy;
    int j;
    for (int p = 0; p < n; p++) begin
      if (lay == LAYOUT_COINCIDE && p > 0 && $urandom_range(1)) begin
        cx = frame[frame.size() - 2].pos_x;
        cy = frame[frame.size() - 2].pos_y;
      end else begin
        cx = 32'($signed($urandom_range(524287)) - 262144);
        cy = 32'($signed($urandom_range(524287)) - 262144);
      end
      for (int sl = 0; sl < 3; sl++) begin
        it.slot  = SLOT_W'(sl);
        it.part  = PART_W'(p);
        it.last  = 1'b0;
        it.pos_x = sl == 1 ? (lay == LAYOUT_EXTREME || lay == LAYOUT_WIDE ?
                              pick_coord(lay, cx) : cx) : pick_coord(lay, cx);
        it.pos_y = sl == 1 ? (lay == LAYOUT_EXTREME || lay == LAYOUT_WIDE ?
                              pick_coord(lay, cy) : cy) : pick_coord(lay, cy);
        frame.push_back(it);
      end
    end
    frame.shuffle();
    // The marked item must name the highest particle, since it sets the count.
    for (j = 0; j < frame.size(); j++) if (frame[j].part == PART_W'(n - 1)) break;
    it = frame[j];
    frame.delete(j);
    it.last = 1'b1;
    frame.push_back(it);
    foreach (frame[i]) begin
      // Sprinkle ignored slot items and writes beyond the frame that are never read.
      if ($urandom_range(19) == 0) begin
        pending_items.push_back('{SLOT_NONE, PART_W'($urandom), $urandom, $urandom,
                                  1'($urandom)});
      end
      if ($urandom_range(29) == 0) begin
        pending_items.push_back('{SLOT_W'($urandom_range(2)),
                                  PART_W'($urandom_range(63, 40)), $urandom, $urandom, 1'b0});
      end
      pending_items.push_back(frame[i]);
    end
  endtask

  task automatic random_phase(int frames);
    layout_e lay;
    int n;
    for (int f = 0; f < frames; f++) begin
      n = $urandom_range(15) == 0 ? $urandom_range(12, 7) : $urandom_range(6, 2);
      case ($urandom_range(9))
        0: lay = LAYOUT_WIDE;
        1: lay = LAYOUT_EXTREME;
        2, 3: lay = LAYOUT_COINCIDE;
        default: lay = LAYOUT_NEAR;
      endcase
      push_frame(n, lay);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_AMP;
    cfg_data_i = '0;
    item_taken = 1'b0;
    no_idle = 1'b0;
    errors = 0;
    idle_cycles = 0;
    amp_reg = AMP_RESET;
    dt2_reg = DT2_RESET;
    part_count = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, coinciding particles, ignored items, the top particle index.
    pending_items.push_back('{SLOT_NONE, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    pending_items.push_back('{SLOT_NEXT, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0});
    push_frame(2, LAYOUT_EXTREME);
    push_frame(3, LAYOUT_COINCIDE);
    push_frame(2, LAYOUT_NEAR);
    wait_drained();

    write_reg(REG_AMP, 32'h7FFF_FFFF);
    write_reg(REG_DT2, 32'hFFFF_FFFF);
    push_frame(2, LAYOUT_NEAR);
    push_frame(3, LAYOUT_EXTREME);
    wait_drained();

    write_reg(REG_AMP, 32'h8000_0000);
    write_reg(REG_DT2, 32'd0);
    push_frame(3, LAYOUT_NEAR);
    wait_drained();

    // A larger frame once, then random phases over varied register settings.
    write_reg(REG_AMP, 32'hFFFF_0000);
    write_reg(REG_DT2, 32'h0100_0000);
    push_frame(24, LAYOUT_NEAR);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_AMP, ph == 0 ? AMP_RESET : $urandom);
      write_reg(REG_DT2, ph == 0 ? DT2_RESET : $urandom);
      no_idle = (ph == 3);
      random_phase(14);
      wait_drained();
    end
    no_idle = 1'b0;

    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
